@@ hw/rtl/stks_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_pkg
// Shared types and constants for the salience top-k selector.
// ----------------------------------------------------------------------------
package stks_pkg;

    localparam int SLOTS       = 64;
    localparam int COUNT_W     = 7;
    localparam int COL_W       = 12;
    localparam int ROW_W       = 12;
    localparam int SAL_W       = 16;
    localparam int SLOT_IDX_W  = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = 2;
    localparam int QCNT_W      = 3;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(SLOTS);

    typedef struct packed {
        logic [SAL_W-1:0] sal;
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic             last;
    } item_t;

    // Clamp the written count to 1..SLOTS
    function automatic logic [COUNT_W-1:0] eff_count(input logic [COUNT_W-1:0] k);
        logic [COUNT_W-1:0] r;
        begin
            r = k;
            if (k == '0)
            begin
                r = COUNT_W'(1);
            end
            else if (k > COUNT_W'(SLOTS))
            begin
                r = COUNT_W'(SLOTS);
            end
            return r;
        end
    endfunction

endpackage

@@ hw/rtl/salience_top_k_select.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salience_top_k_select
// Keeps the most salient pixels of a raster frame and reports them at frame end.
// ----------------------------------------------------------------------------
// Usage:
//   in channel  : one pixel word per handshake (position, two averages,
//                 frame_end on the last pixel of the frame).
//   out channel : at frame end, kept_count words (clamped to 1..64) from highest salience down;
//                 end_of_list marks the last one.
//   cfg channel : kept_count, always ready; write it between frames.
// Throughput: one pixel per cycle within a frame while no readout is under
//   way. The insertion list compares all 64 slots in parallel.
// Path: a pixel passes the front register and the queue to the list.
//   After the frame-end pixel enters the list, the state turns to readout
//   and the output register takes the first result word; readout then gives
//   one word a cycle while the receiver is ready, shifting the list out through slot 0.
// During readout the list takes no pixel; the front register and the
//   four-word queue absorb up to five pixels before in_ready drops.
// If the receiver stalls, the output register holds its word and readout
//   waits. Reset empties all slots (salience 0, position 0,0), sets
//   kept_count to 64 and drops every valid.
// ----------------------------------------------------------------------------
module salience_top_k_select (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  kept_count,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [11:0] pixel_col,
    input  logic [11:0] pixel_row,
    input  logic [15:0] same_avg,
    input  logic [15:0] different_avg,
    input  logic        frame_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [11:0] kept_col,
    output logic [11:0] kept_row,
    output logic [15:0] kept_salience,
    output logic        end_of_list
);
    import stks_pkg::*;

    logic  push_valid;
    logic  push_ready;
    item_t push_item;
    logic  pop_valid;
    logic  pop_ready;
    item_t pop_item;

    stks_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .same_avg      (same_avg),
        .different_avg (different_avg),
        .frame_end     (frame_end),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_item     (push_item)
    );

    stks_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    stks_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .kept_count    (kept_count),
        .pop_valid     (pop_valid),
        .pop_ready     (pop_ready),
        .pop_item      (pop_item),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kept_col      (kept_col),
        .kept_row      (kept_row),
        .kept_salience (kept_salience),
        .end_of_list   (end_of_list)
    );

endmodule

@@ hw/rtl/stks_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_front
// Accepts pixel words, forms the salience and registers the item for the queue.
// ----------------------------------------------------------------------------
module stks_front (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic [11:0]               pixel_col,
    input  logic [11:0]               pixel_row,
    input  logic [15:0]               same_avg,
    input  logic [15:0]               different_avg,
    input  logic                      frame_end,
    output logic                      push_valid,
    input  logic                      push_ready,
    output stks_pkg::item_t           push_item
);
    import stks_pkg::*;

    logic  f_valid_reg;
    logic  f_valid_next;
    item_t f_item_reg;
    item_t f_item_next;
    logic  take;

    assign in_ready   = !f_valid_reg || push_ready;
    assign take       = in_valid && in_ready;
    assign push_valid = f_valid_reg;
    assign push_item  = f_item_reg;

    always_comb
    begin
        f_item_next = f_item_reg;
        f_valid_next = f_valid_reg;
        if (take)
        begin
            f_valid_next     = 1'b1;
            f_item_next.sal  = (same_avg >= different_avg) ? (same_avg - different_avg)
                                                           : (different_avg - same_avg);
            f_item_next.col  = pixel_col;
            f_item_next.row  = pixel_row;
            f_item_next.last = frame_end;
        end
        else if (push_ready)
        begin
            f_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            f_valid_reg <= 1'b0;
        end
        else
        begin
            f_valid_reg <= f_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        f_item_reg <= f_item_next;
    end

endmodule

@@ hw/rtl/stks_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_queue
// Short FIFO between the front and the insertion list.
// ----------------------------------------------------------------------------
module stks_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  stks_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output stks_pkg::item_t pop_item
);
    import stks_pkg::*;

    item_t             mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] cnt_reg;
    logic [QCNT_W-1:0] cnt_next;
    logic              do_push;
    logic              do_pop;

    assign push_ready = (cnt_reg != QCNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + QCNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

@@ hw/rtl/stks_back.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_back
// Sorted insertion list of salient pixels with frame-end readout.
// ----------------------------------------------------------------------------
module stks_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [6:0]      kept_count,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  stks_pkg::item_t pop_item,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [11:0]     kept_col,
    output logic [11:0]     kept_row,
    output logic [15:0]     kept_salience,
    output logic            end_of_list
);
    import stks_pkg::*;

    localparam logic ST_RUN   = 1'b0;
    localparam logic ST_DRAIN = 1'b1;

    logic                  state_reg;
    logic                  state_next;
    logic [COUNT_W-1:0]    k_reg;
    logic [SLOT_IDX_W-1:0] cnt_reg;
    logic [SLOT_IDX_W-1:0] cnt_next;

    logic [SAL_W-1:0] sal_reg  [SLOTS];
    logic [COL_W-1:0] col_reg  [SLOTS];
    logic [ROW_W-1:0] row_reg  [SLOTS];
    logic [SAL_W-1:0] sal_next [SLOTS];
    logic [COL_W-1:0] col_next [SLOTS];
    logic [ROW_W-1:0] row_next [SLOTS];

    logic [SLOTS-1:0] lt;
    logic [SLOTS-1:0] head;

    logic             out_valid_reg;
    logic             out_valid_next;
    logic [COL_W-1:0] out_col_reg;
    logic [ROW_W-1:0] out_row_reg;
    logic [SAL_W-1:0] out_sal_reg;
    logic             out_eol_reg;

    logic take;
    logic emit;
    logic last_emit;

    assign cfg_ready     = 1'b1;
    assign pop_ready     = (state_reg == ST_RUN);
    assign take          = pop_valid && pop_ready;
    assign emit          = (state_reg == ST_DRAIN) && (!out_valid_reg || out_ready);
    assign last_emit     = emit && ({1'b0, cnt_reg} == (k_reg - COUNT_W'(1)));
    assign out_valid     = out_valid_reg;
    assign kept_col      = out_col_reg;
    assign kept_row      = out_row_reg;
    assign kept_salience = out_sal_reg;
    assign end_of_list   = out_eol_reg;

    // Slots that lose to the new pixel form a tail of the active list
    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            lt[i] = (COUNT_W'(i) < k_reg) && (sal_reg[i] < pop_item.sal);
        end
        head = lt & ~{lt[SLOTS-2:0], 1'b0};
    end

    always_comb
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            sal_next[i] = sal_reg[i];
            col_next[i] = col_reg[i];
            row_next[i] = row_reg[i];
        end
        if (take)
        begin
            // insert at the head of the losing tail, push the rest down
            for (int i = 0; i < SLOTS; i++)
            begin
                if (head[i])
                begin
                    sal_next[i] = pop_item.sal;
                    col_next[i] = pop_item.col;
                    row_next[i] = pop_item.row;
                end
            end
            for (int i = 1; i < SLOTS; i++)
            begin
                if (lt[i] && !head[i])
                begin
                    sal_next[i] = sal_reg[i-1];
                    col_next[i] = col_reg[i-1];
                    row_next[i] = row_reg[i-1];
                end
            end
        end
        else if (last_emit)
        begin
            for (int i = 0; i < SLOTS; i++)
            begin
                sal_next[i] = '0;
                col_next[i] = '0;
                row_next[i] = '0;
            end
        end
        else if (emit)
        begin
            // advance the list towards slot 0
            for (int i = 0; i < SLOTS - 1; i++)
            begin
                sal_next[i] = sal_reg[i+1];
                col_next[i] = col_reg[i+1];
                row_next[i] = row_reg[i+1];
            end
            sal_next[SLOTS-1] = '0;
            col_next[SLOTS-1] = '0;
            row_next[SLOTS-1] = '0;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            ST_RUN:
            begin
                if (take && pop_item.last)
                begin
                    state_next = ST_DRAIN;
                    cnt_next   = '0;
                end
            end
            ST_DRAIN:
            begin
                if (emit)
                begin
                    out_valid_next = 1'b1;
                    cnt_next       = cnt_reg + SLOT_IDX_W'(1);
                    if (last_emit)
                    begin
                        state_next = ST_RUN;
                    end
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            cnt_reg       <= '0;
            k_reg         <= COUNT_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < SLOTS; i++)
            begin
                sal_reg[i] <= '0;
                col_reg[i] <= '0;
                row_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                k_reg <= eff_count(kept_count);
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                sal_reg[i] <= sal_next[i];
                col_reg[i] <= col_next[i];
                row_reg[i] <= row_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            out_col_reg <= col_reg[0];
            out_row_reg <= row_reg[0];
            out_sal_reg <= sal_reg[0];
            out_eol_reg <= last_emit;
        end
    end

endmodule

@@ hw/rtl/stks_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stks_checker
// Port-level checks on the result stream of the salience top-k selector.
// ----------------------------------------------------------------------------
module stks_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [11:0] kept_col,
    input logic [11:0] kept_row,
    input logic [15:0] kept_salience,
    input logic        end_of_list
);

    logic        in_list_reg;
    logic [15:0] last_sal_reg;

    // Track the previous word of the list being read out
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_list_reg  <= 1'b0;
            last_sal_reg <= '0;
        end
        else if (out_valid && out_ready)
        begin
            in_list_reg  <= !end_of_list;
            last_sal_reg <= kept_salience;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kept_col) && $stable(kept_row)
            && $stable(kept_salience) && $stable(end_of_list))
        else $error("result word changed while stalled");

    a_descending: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && in_list_reg |-> kept_salience <= last_sal_reg)
        else $error("result list not in descending salience");

    a_empty_slot: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kept_salience == 16'd0) |-> (kept_col == 12'd0) && (kept_row == 12'd0))
        else $error("zero-salience word with non-zero position");

endmodule

bind salience_top_k_select stks_checker u_stks_checker (.*);

@@ tb/sv/salience_top_k_select_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// salience_top_k_select_tb
// Self-checking bench for the salience top-k selector: pixel frames are fed
// through the in channel, a local ranking list predicts the words read out at
// each frame end, and every output word is compared field by field. Directed
// frames cover the field extremes and count corner cases, then random frames
// run with random gaps and receiver stalls, a long receiver hold-off and a
// final stretch at full rate.
// ----------------------------------------------------------------------------
module salience_top_k_select_tb;

    import stks_pkg::*;

    localparam int QUIET_PAD   = 16;
    localparam int CYCLE_LIMIT = 1000000;

    typedef struct packed {
        logic [COL_W-1:0] col;
        logic [ROW_W-1:0] row;
        logic [SAL_W-1:0] sal;
        logic             last;
    } kept_word_t;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [COUNT_W-1:0] kept_count = '0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COL_W-1:0]   pixel_col = '0;
    logic [ROW_W-1:0]   pixel_row = '0;
    logic [SAL_W-1:0]   same_avg = '0;
    logic [SAL_W-1:0]   different_avg = '0;
    logic               frame_end = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COL_W-1:0]   kept_col;
    logic [ROW_W-1:0]   kept_row;
    logic [SAL_W-1:0]   kept_salience;
    logic               end_of_list;

    // Local copy of the ranking list and its count register
    logic [SAL_W-1:0]   rank_sal [SLOTS];
    logic [COL_W-1:0]   rank_col [SLOTS];
    logic [ROW_W-1:0]   rank_row [SLOTS];
    logic [COUNT_W-1:0] kept_limit = COUNT_W'(SLOTS);

    kept_word_t pending_words [$];
    int         fail_count = 0;
    int         sent_count = 0;
    int         cycle_count = 0;
    int         rx_hold_len = 0;
    bit         idle_on = 1'b1;

    salience_top_k_select dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .kept_count    (kept_count),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .pixel_col     (pixel_col),
        .pixel_row     (pixel_row),
        .same_avg      (same_avg),
        .different_avg (different_avg),
        .frame_end     (frame_end),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .kept_col      (kept_col),
        .kept_row      (kept_row),
        .kept_salience (kept_salience),
        .end_of_list   (end_of_list)
    );

    always #1 clk = ~clk;

    initial
    begin
        for (int i = 0; i < SLOTS; i++)
        begin
            rank_sal[i] = '0;
            rank_col[i] = '0;
            rank_row[i] = '0;
        end
    end

    function automatic int active_slots();
        int k;
        k = int'(kept_limit);
        if (k < 1)
        begin
            k = 1;
        end
        else if (k > SLOTS)
        begin
            k = SLOTS;
        end
        return k;
    endfunction

    // Insert one pixel into the ranking list; on frame end queue the readout
    task automatic rank_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [SAL_W-1:0] a, input logic [SAL_W-1:0] b,
                              input logic last);
        logic [SAL_W-1:0] sal;
        logic [SAL_W-1:0] ts;
        logic [COL_W-1:0] c;
        logic [COL_W-1:0] tc;
        logic [ROW_W-1:0] r;
        logic [ROW_W-1:0] tr;
        kept_word_t       w;
        int               k;
        int               pos;
        sal = (a >= b) ? a - b : b - a;
        c = col;
        r = row;
        k = active_slots();
        pos = k;
        while (pos > 0 && rank_sal[pos-1] < sal)
        begin
            pos--;
        end
        for (; pos < k; pos++)
        begin
            ts = rank_sal[pos];
            tc = rank_col[pos];
            tr = rank_row[pos];
            rank_sal[pos] = sal;
            rank_col[pos] = c;
            rank_row[pos] = r;
            sal = ts;
            c = tc;
            r = tr;
        end
        if (last)
        begin
            for (int i = 0; i < k; i++)
            begin
                w.col = rank_col[i];
                w.row = rank_row[i];
                w.sal = rank_sal[i];
                w.last = (i == k - 1);
                pending_words.push_back(w);
            end
            for (int i = 0; i < SLOTS; i++)
            begin
                rank_sal[i] = '0;
                rank_col[i] = '0;
                rank_row[i] = '0;
            end
        end
    endtask

    // Sample handshakes on the falling edge ahead of the rising edge that completes them
    always @(negedge clk)
    begin : monitor
        kept_word_t w;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_words.size() == 0)
            begin
                $error("result word with none expected: col %0d row %0d salience %0d",
                       kept_col, kept_row, kept_salience);
                fail_count++;
            end
            else
            begin
                w = pending_words.pop_front();
                if (kept_col !== w.col)
                begin
                    $error("kept_col: expected %0d, got %0d", w.col, kept_col);
                    fail_count++;
                end
                if (kept_row !== w.row)
                begin
                    $error("kept_row: expected %0d, got %0d", w.row, kept_row);
                    fail_count++;
                end
                if (kept_salience !== w.sal)
                begin
                    $error("kept_salience: expected %0d, got %0d", w.sal, kept_salience);
                    fail_count++;
                end
                if (end_of_list !== w.last)
                begin
                    $error("end_of_list: expected %0d, got %0d", w.last, end_of_list);
                    fail_count++;
                end
            end
        end
        if (rst_n && cfg_valid && cfg_ready)
        begin
            kept_limit = kept_count;
        end
        if (rst_n && in_valid && in_ready)
        begin
            rank_pixel(pixel_col, pixel_row, same_avg, different_avg, frame_end);
        end
    end

    // Receiver: random stall bursts, or a long hold-off when one is requested
    initial
    begin : receiver
        int n;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (rx_hold_len > 0)
            begin
                n = rx_hold_len;
                rx_hold_len = 0;
                out_ready <= 1'b0;
                repeat (n) @(posedge clk);
                out_ready <= 1'b1;
            end
            else if (idle_on && $urandom_range(0, 7) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge clk);
                out_ready <= 1'b1;
            end
            else
            begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("salience_top_k_select_tb NOT OK");
            $finish;
        end
    end

    task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                              input logic [SAL_W-1:0] a, input logic [SAL_W-1:0] b,
                              input logic last);
        logic acc;
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        in_valid <= 1'b1;
        pixel_col <= col;
        pixel_row <= row;
        same_avg <= a;
        different_avg <= b;
        frame_end <= last;
        do
        begin
            @(negedge clk);
            acc = in_ready;
            @(posedge clk);
        end
        while (!acc);
        sent_count++;
    endtask

    task automatic send_random_pixel(input logic last);
        logic [SAL_W-1:0] a;
        logic [SAL_W-1:0] b;
        case ($urandom_range(0, 3))
            0:
            begin
                a = SAL_W'($urandom);
                b = SAL_W'($urandom);
            end
            1:
            begin
                // narrow range: plenty of ties and zeros
                a = SAL_W'($urandom_range(0, 3));
                b = SAL_W'($urandom_range(0, 3));
            end
            2:
            begin
                a = SAL_W'($urandom);
                b = a;
            end
            default:
            begin
                a = SAL_W'($urandom_range(65000, 65535));
                b = SAL_W'($urandom_range(0, 600));
            end
        endcase
        send_pixel(COL_W'($urandom), ROW_W'($urandom), a, b, last);
    endtask

    task automatic send_random_frame(input int len);
        for (int i = 0; i < len; i++)
        begin
            send_random_pixel(i == len - 1);
        end
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        logic acc;
        @(posedge clk);
        cfg_valid <= 1'b1;
        kept_count <= value;
        do
        begin
            @(negedge clk);
            acc = cfg_ready;
            @(posedge clk);
        end
        while (!acc);
        cfg_valid <= 1'b0;
    endtask

    // Drop valid, wait for every expected word, then let the pipeline drain
    task automatic wait_quiet();
        in_valid <= 1'b0;
        while (pending_words.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (QUIET_PAD) @(posedge clk);
    endtask

    function automatic logic [COUNT_W-1:0] pick_count();
        case ($urandom_range(0, 9))
            0: return COUNT_W'(0);
            1: return COUNT_W'(127);
            2: return COUNT_W'(SLOTS);
            3: return COUNT_W'($urandom_range(SLOTS + 1, 126));
            4: return COUNT_W'($urandom_range(9, SLOTS - 1));
            default: return COUNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Reset count of 64 and a frame with nothing salient: all slots read as empty
    task automatic test_empty_frame();
        send_pixel(12'd4095, 12'd4095, 16'h8000, 16'h8000, 1'b1);
        wait_quiet();
    endtask

    task automatic test_field_extremes();
        write_count(COUNT_W'(127));
        send_pixel(12'd4095, 12'd0, 16'hFFFF, 16'h0000, 1'b0);
        send_pixel(12'd0, 12'd4095, 16'h0000, 16'hFFFF, 1'b0);
        send_pixel(12'd100, 12'd200, 16'd1, 16'd0, 1'b0);
        send_pixel(12'd2048, 12'd2048, 16'h5555, 16'hAAAA, 1'b0);
        send_pixel(12'd1365, 12'd2730, 16'hAAAA, 16'h5555, 1'b0);
        send_pixel(12'd4095, 12'd4095, 16'd300, 16'd300, 1'b1);
        wait_quiet();
    endtask

    task automatic test_count_zero();
        write_count(COUNT_W'(0));
        send_pixel(12'd1, 12'd1, 16'd10, 16'd0, 1'b0);
        send_pixel(12'd2, 12'd2, 16'd20, 16'd0, 1'b0);
        send_pixel(12'd3, 12'd3, 16'd0, 16'd20, 1'b0);
        send_pixel(12'd4, 12'd4, 16'd5, 16'd0, 1'b1);
        wait_quiet();
    endtask

    task automatic test_short_list();
        write_count(COUNT_W'(3));
        send_pixel(12'd10, 12'd1, 16'd7, 16'd0, 1'b0);
        send_pixel(12'd11, 12'd2, 16'd0, 16'd9, 1'b0);
        send_pixel(12'd12, 12'd3, 16'd7, 16'd0, 1'b0);
        send_pixel(12'd13, 12'd4, 16'd9, 16'd0, 1'b0);
        send_pixel(12'd14, 12'd5, 16'd8, 16'd0, 1'b1);
        wait_quiet();
    endtask

    task automatic test_count_mid_frame();
        write_count(COUNT_W'(8));
        send_pixel(12'd21, 12'd1, 16'd400, 16'd0, 1'b0);
        send_pixel(12'd22, 12'd2, 16'd300, 16'd0, 1'b0);
        send_pixel(12'd23, 12'd3, 16'd200, 16'd0, 1'b0);
        send_pixel(12'd24, 12'd4, 16'd100, 16'd0, 1'b0);
        wait_quiet();
        write_count(COUNT_W'(2));
        send_pixel(12'd25, 12'd5, 16'd350, 16'd0, 1'b0);
        send_pixel(12'd26, 12'd6, 16'd50, 16'd0, 1'b1);
        wait_quiet();
        // slots beyond the short count must have been cleared by the readout
        write_count(COUNT_W'(8));
        send_pixel(12'd27, 12'd7, 16'd9, 16'd9, 1'b1);
        wait_quiet();
    endtask

    // Hold the receiver off across a readout so the front register and queue fill up
    task automatic test_output_stall();
        write_count(COUNT_W'(SLOTS));
        rx_hold_len = 400;
        send_random_frame(10);
        send_random_frame(14);
        wait_quiet();
    endtask

    task automatic test_random_frames();
        int len;
        while (sent_count < 110)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                wait_quiet();
                write_count(pick_count());
            end
            idle_on = ($urandom_range(0, 3) != 0);
            len = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 12);
            send_random_frame(len);
        end
        wait_quiet();
    endtask

    task automatic test_full_rate();
        idle_on = 1'b0;
        write_count(COUNT_W'($urandom_range(1, 8)));
        while (sent_count < 160)
        begin
            send_random_frame($urandom_range(1, 12));
        end
        wait_quiet();
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_frame();
        test_field_extremes();
        test_count_zero();
        test_short_list();
        test_count_mid_frame();
        test_output_stall();
        test_random_frames();
        test_full_rate();
        if (fail_count == 0)
        begin
            $display("salience_top_k_select_tb OK");
        end
        else
        begin
            $display("salience_top_k_select_tb NOT OK");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/stks_pkg.sv
hw/rtl/stks_front.sv
hw/rtl/stks_queue.sv
hw/rtl/stks_back.sv
hw/rtl/salience_top_k_select.sv
hw/rtl/stks_checker.sv
tb/sv/salience_top_k_select_tb.sv
